FILE: rtl/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
// Used by wbps_cfg, wbps_core and wildcard_byte_pattern_scan; no dependencies.
`default_nettype none

package wbps_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int REG_BYTES         = 32;   // pattern bytes the registers can hold
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_IDX_W         = 3;
    localparam int LEN_W             = 6;    // holds 1..32
    localparam int OFFSET_W          = 32;
    localparam int BYTE_W            = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_0_7   = 3'd0,
        REG_PAT_8_15  = 3'd1,
        REG_PAT_16_23 = 3'd2,
        REG_PAT_24_31 = 3'd3,
        REG_WILDCARD  = 3'd4,
        REG_LENGTH    = 3'd5
    } t_reg_idx;

    // One result word from the scan core to the output register
    typedef struct packed {
        logic                valid;
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/wbps_cfg.sv
// Configuration registers and the pattern aligned to the byte window.
// Depends on wbps_pkg.
`default_nettype none

module wbps_cfg #(
    parameter int CAP = wbps_pkg::REG_BYTES
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [wbps_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic      [wbps_pkg::BYTE_W-1:0]      o_alig [CAP],
    output logic      [CAP-1:0]                   o_care,
    output logic      [wbps_pkg::LEN_W-1:0]       o_len
);

    localparam int PAT_W = wbps_pkg::REG_BYTES * wbps_pkg::BYTE_W;

    logic [PAT_W-1:0]               r_pat;
    logic [wbps_pkg::REG_BYTES-1:0] r_mask;
    logic [wbps_pkg::LEN_W-1:0]     r_len_raw;

    logic [wbps_pkg::LEN_W-1:0]  r_len, n_len;
    logic [wbps_pkg::BYTE_W-1:0] r_alig [CAP];
    logic [wbps_pkg::BYTE_W-1:0] n_alig [CAP];
    logic [CAP-1:0]              r_care, n_care;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat     <= '0;
            r_mask    <= '0;
            r_len_raw <= wbps_pkg::LEN_W'(1);
        end else if (i_cfg_we) begin
            case (wbps_pkg::t_reg_idx'(i_cfg_idx))
                wbps_pkg::REG_PAT_0_7:   r_pat[0*64 +: 64] <= i_cfg_data;
                wbps_pkg::REG_PAT_8_15:  r_pat[1*64 +: 64] <= i_cfg_data;
                wbps_pkg::REG_PAT_16_23: r_pat[2*64 +: 64] <= i_cfg_data;
                wbps_pkg::REG_PAT_24_31: r_pat[3*64 +: 64] <= i_cfg_data;
                wbps_pkg::REG_WILDCARD:  r_mask <= i_cfg_data[wbps_pkg::REG_BYTES-1:0];
                wbps_pkg::REG_LENGTH:    r_len_raw <= i_cfg_data[wbps_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Window entry k (newest at 0) lines up with pattern byte len-1-k.
    always_comb begin
        logic [wbps_pkg::LEN_W-1:0] j;
        if (r_len_raw == '0) begin
            n_len = wbps_pkg::LEN_W'(1);
        end else if (r_len_raw > wbps_pkg::LEN_W'(CAP)) begin
            n_len = wbps_pkg::LEN_W'(CAP);
        end else begin
            n_len = r_len_raw;
        end
        for (int k = 0; k < CAP; k++) begin
            j         = n_len - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(k);
            n_alig[k] = r_pat[{j[4:0], 3'b000} +: 8];
            n_care[k] = (wbps_pkg::LEN_W'(k) < n_len) && !r_mask[j[4:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= wbps_pkg::LEN_W'(1);
            r_care <= CAP'(1);
            for (int k = 0; k < CAP; k++) r_alig[k] <= '0;
        end else begin
            r_len  <= n_len;
            r_care <= n_care;
            for (int k = 0; k < CAP; k++) r_alig[k] <= n_alig[k];
        end
    end

    assign o_alig = r_alig;
    assign o_care = r_care;
    assign o_len  = r_len;

endmodule

`default_nettype wire

FILE: rtl/wbps_core.sv
// Scan state (byte window, byte count, matched flag) and the masked compare.
// Depends on wbps_pkg.
`default_nettype none

module wbps_core #(
    parameter int CAP = wbps_pkg::REG_BYTES
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire logic [wbps_pkg::BYTE_W-1:0]  i_byte,
    input  wire logic                         i_last,
    input  wire logic [wbps_pkg::BYTE_W-1:0]  i_alig [CAP],
    input  wire logic [CAP-1:0]               i_care,
    input  wire logic [wbps_pkg::LEN_W-1:0]   i_len,
    output wbps_pkg::t_result                 o_res
);

    localparam int OW = wbps_pkg::OFFSET_W;

    logic [wbps_pkg::BYTE_W-1:0] r_win [CAP];
    logic [wbps_pkg::BYTE_W-1:0] n_win [CAP];
    logic [OW-1:0]               r_seen, n_seen, seen_inc;
    logic                        r_matched, n_matched;
    logic                        hit;
    wbps_pkg::t_result           res;

    always_comb begin
        n_win[0] = i_byte;
        for (int k = 1; k < CAP; k++) n_win[k] = r_win[k-1];

        seen_inc = (r_seen == '1) ? r_seen : r_seen + OW'(1);

        hit = (seen_inc >= OW'(i_len));
        for (int k = 0; k < CAP; k++) begin
            if (i_care[k] && (n_win[k] != i_alig[k])) hit = 1'b0;
        end

        res        = '0;
        n_seen     = r_seen;
        n_matched  = r_matched;
        if (!r_matched) begin
            n_seen = seen_inc;
            if (hit) begin
                n_matched  = 1'b1;
                res.valid  = 1'b1;
                res.found  = 1'b1;
                res.offset = seen_inc - OW'(i_len);
            end else if (i_last) begin
                res.valid = 1'b1;
            end
        end
        if (i_last) begin
            n_seen    = '0;
            n_matched = 1'b0;
        end
        if (!i_step) res.valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_matched <= 1'b0;
        end else if (i_step) begin
            r_seen    <= n_seen;
            r_matched <= n_matched;
        end
    end

    // window freezes once matched, until the image ends
    always_ff @(posedge i_clk) begin
        if (i_step && !r_matched) begin
            for (int k = 0; k < CAP; k++) r_win[k] <= n_win[k];
        end
    end

    assign o_res = res;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> (r_seen == '0) && !r_matched)
        else $error("scan state not cleared after last byte");

    a_quiet_after_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_matched |-> !o_res.valid)
        else $error("result produced after match in same image");

    a_match_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.found && !i_last |=> r_matched)
        else $error("match reported without setting matched flag");

endmodule

`default_nettype wire

FILE: rtl/wildcard_byte_pattern_scan.sv
// Top level: input word register, scan core, config block, output register.
// Depends on wbps_pkg, wbps_cfg, wbps_core.
//
//  channel | direction | tdata                 | tuser        | tlast
//  s       | in        | [7:0] image_byte      | -            | end_of_image
//  m       | out       | [31:0] match_offset   | [0] found    | -
//  cfg     | in        | 64-bit register write, index 0..5, no read-back
//
// One word per cycle unless stalled: the masked window compare and state update
// run while a word sits in the input register, and any result it yields is
// captured in the output register when the word steps out. The output register
// stalls the input register only while a result is held and m is not ready.
// Reset is synchronous, active low; config regs feed the compare through one
// register stage, so a word compared in the cycle right after a write still
// sees the old values; new values apply from the cycle after that.
`default_nettype none

module wildcard_byte_pattern_scan #(
    parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [7:0]                       i_s_tdata,   // [7:0] image_byte
    input  wire logic                             i_s_tlast,   // end_of_image
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic      [31:0]                      o_m_tdata,   // [31:0] match_offset
    output logic                                  o_m_tuser,   // [0] match_found
    input  wire logic                             i_cfg_we,
    input  wire logic [wbps_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CAP = (MAX_PATTERN_BYTES < wbps_pkg::REG_BYTES) ?
                         MAX_PATTERN_BYTES : wbps_pkg::REG_BYTES;

    logic                        r_in_valid;
    logic [wbps_pkg::BYTE_W-1:0] r_in_byte;
    logic                        r_in_last;
    logic                        r_out_valid;
    logic                        r_out_found;
    logic [wbps_pkg::OFFSET_W-1:0] r_out_offset;
    logic                        step;

    logic [wbps_pkg::BYTE_W-1:0] alig [CAP];
    logic [CAP-1:0]              care;
    logic [wbps_pkg::LEN_W-1:0]  len;
    wbps_pkg::t_result           res;

    assign step       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    wbps_cfg #(.CAP(CAP)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_alig     (alig),
        .o_care     (care),
        .o_len      (len)
    );

    wbps_core #(.CAP(CAP)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_alig  (alig),
        .i_care  (care),
        .i_len   (len),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out_found  <= res.found;
            r_out_offset <= res.offset;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_found;
    assign o_m_tdata  = r_out_offset;

    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("no-match result with nonzero offset");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |-> !res.valid)
        else $error("held result overwritten");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_tready)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire
